/* hw/rtl/ledtw_pkg.sv */
package ledtw_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COMMAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_COMMAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_COMMAND = 3'd4;

  // Register reset values.
  localparam logic [3:0] BRIGHTNESS_RST      = 4'd0;
  localparam logic [1:0] START_POSITION_RST  = 2'd0;
  localparam logic [7:0] DATA_COMMAND_RST    = 8'h40;
  localparam logic [7:0] ADDRESS_COMMAND_RST = 8'hC0;
  localparam logic [7:0] CONTROL_COMMAND_RST = 8'h80;

  // Operation codes carried in the input tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Digits that the input beat can supply.
  localparam int unsigned INPUT_DIGITS = 4;

  typedef struct packed {
    logic [3:0] brightness;
    logic [1:0] start_position;
    logic [7:0] data_command;
    logic [7:0] address_command;
    logic [7:0] control_command;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] segment_first;
    logic [7:0] segment_second;
    logic [7:0] segment_third;
    logic [7:0] segment_fourth;
    logic       dio_sample;
  } item_t;

  typedef struct packed {
    logic clock_pull_low;
    logic data_pull_low;
    logic busy_res;
    logic ack_missing;
    logic frame_done;
  } result_t;

endpackage

/* hw/rtl/ledtw_engine.sv */
module ledtw_engine #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ledtw_pkg::item_t  item_i,
  input  ledtw_pkg::cfg_t   cfg_i,
  output ledtw_pkg::result_t result_o
);

  localparam int unsigned BYTE_W = $clog2(DIGIT_COUNT + 1);
  localparam logic [BYTE_W-1:0] LAST_DIGIT = BYTE_W'(DIGIT_COUNT);

  // Part of a transfer.
  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_BODY  = 2'd1;
  localparam logic [1:0] SEG_STOP  = 2'd2;

  // Transfer within a frame.
  localparam logic [1:0] XFER_DATA = 2'd0;
  localparam logic [1:0] XFER_ADDR = 2'd1;
  localparam logic [1:0] XFER_CTRL = 2'd2;

  // Bit slot eight is the acknowledge.
  localparam logic [3:0] ACK_SLOT = 4'd8;

  logic              busy_q, busy_d;
  logic [1:0]        xfer_q, xfer_d;
  logic [1:0]        seg_q, seg_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [3:0]        bit_q, bit_d;
  logic [1:0]        sub_q, sub_d;
  logic              clk_low_q, clk_low_d;
  logic              data_low_q, data_low_d;
  logic              nack_q, nack_d;
  logic              done;
  logic [7:0]        digit_q [DIGIT_COUNT];
  logic [7:0]        digit_d [DIGIT_COUNT];
  logic [7:0]        seg_in [ledtw_pkg::INPUT_DIGITS];
  logic [7:0]        cur_byte;
  logic              last_byte;

  assign seg_in[0] = item_i.segment_first;
  assign seg_in[1] = item_i.segment_second;
  assign seg_in[2] = item_i.segment_third;
  assign seg_in[3] = item_i.segment_fourth;

  always_comb begin
    case (xfer_q)
      XFER_DATA: cur_byte = cfg_i.data_command;
      XFER_ADDR: begin
        if (byte_q == '0) begin
          cur_byte = cfg_i.address_command + {6'd0, cfg_i.start_position};
        end else begin
          cur_byte = digit_q[0];
        end
      end
      default: cur_byte = cfg_i.control_command + {4'd0, cfg_i.brightness};
    endcase
    last_byte = (xfer_q == XFER_ADDR) ? (byte_q == LAST_DIGIT) : 1'b1;
  end

  always_comb begin
    busy_d     = busy_q;
    xfer_d     = xfer_q;
    seg_d      = seg_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    sub_d      = sub_q;
    clk_low_d  = clk_low_q;
    data_low_d = data_low_q;
    nack_d     = nack_q;
    digit_d    = digit_q;
    done       = 1'b0;

    if (step_i) begin
      if (item_i.operation == ledtw_pkg::OP_LOAD) begin
        if (!busy_q) begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_d[i] = (i < ledtw_pkg::INPUT_DIGITS) ? seg_in[2'(i)] : 8'h00;
          end
          busy_d = 1'b1;
          xfer_d = XFER_DATA;
          seg_d  = SEG_START;
          byte_d = '0;
          bit_d  = '0;
          sub_d  = '0;
          nack_d = 1'b0;
        end
      end else if (busy_q) begin
        case (seg_q)
          SEG_START: begin
            data_low_d = 1'b1;
            seg_d      = SEG_BODY;
          end
          SEG_BODY: begin
            if (bit_q != ACK_SLOT) begin
              case (sub_q)
                2'd0:    clk_low_d  = 1'b1;
                2'd1:    data_low_d = !cur_byte[bit_q[2:0]];
                default: clk_low_d  = 1'b0;
              endcase
              if (sub_q == 2'd2) begin
                sub_d = '0;
                bit_d = bit_q + 4'd1;
              end else begin
                sub_d = sub_q + 2'd1;
              end
            end else begin
              case (sub_q)
                2'd0: begin
                  clk_low_d  = 1'b1;
                  data_low_d = 1'b0;
                end
                2'd1: clk_low_d = 1'b0;
                2'd2: begin
                  if (!item_i.dio_sample) begin
                    data_low_d = 1'b1;
                  end else begin
                    nack_d = 1'b1;
                  end
                end
                default: clk_low_d = 1'b1;
              endcase
              if (sub_q == 2'd3) begin
                sub_d = '0;
                bit_d = '0;
                // A finished digit byte moves the next digit to the front.
                if (xfer_q == XFER_ADDR && byte_q != '0) begin
                  for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                    digit_d[i] = digit_q[i+1];
                  end
                  digit_d[DIGIT_COUNT-1] = 8'h00;
                end
                if (last_byte) begin
                  seg_d = SEG_STOP;
                end else begin
                  byte_d = byte_q + BYTE_W'(1);
                end
              end else begin
                sub_d = sub_q + 2'd1;
              end
            end
          end
          SEG_STOP: begin
            case (sub_q)
              2'd0:    data_low_d = 1'b1;
              2'd1:    clk_low_d  = 1'b0;
              default: data_low_d = 1'b0;
            endcase
            if (sub_q == 2'd2) begin
              sub_d  = '0;
              byte_d = '0;
              seg_d  = SEG_START;
              if (xfer_q == XFER_CTRL) begin
                busy_d = 1'b0;
                done   = 1'b1;
                xfer_d = XFER_DATA;
              end else begin
                xfer_d = xfer_q + 2'd1;
              end
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
          default: seg_d = SEG_START;
        endcase
      end
    end
  end

  always_comb begin
    result_o.clock_pull_low = clk_low_d;
    result_o.data_pull_low  = data_low_d;
    result_o.busy_res       = busy_d;
    result_o.ack_missing    = nack_d;
    result_o.frame_done     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      xfer_q     <= XFER_DATA;
      seg_q      <= SEG_START;
      byte_q     <= '0;
      bit_q      <= '0;
      sub_q      <= '0;
      clk_low_q  <= 1'b0;
      data_low_q <= 1'b0;
      nack_q     <= 1'b0;
    end else if (step_i) begin
      busy_q     <= busy_d;
      xfer_q     <= xfer_d;
      seg_q      <= seg_d;
      byte_q     <= byte_d;
      bit_q      <= bit_d;
      sub_q      <= sub_d;
      clk_low_q  <= clk_low_d;
      data_low_q <= data_low_d;
      nack_q     <= nack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      digit_q <= digit_d;
    end
  end

endmodule

/* hw/rtl/led_driver_two_wire_frame_sender_top.sv */
// Channel  | Direction | Payload
// s_axis   | in        | tuser: operation; tdata: four segment bytes, dio_sample
// m_axis   | out       | tdata: pin levels, busy, ack missing; tlast: frame done
// cfg      | in        | write enable, register index, register data
//
// Every input beat produces exactly one output beat, and a new input beat can be taken
// in every cycle while the output is not stalled: the frame sequencer advances once per
// beat and its result lands in a single output register in the cycle after acceptance.
// While that register holds a beat that has not been taken, s_axis_tready is low.
// Reset is asynchronous and active low; it releases both bus lines and idles the block.
// The digit store has no reset and is filled by each load beat taken while idle.
module led_driver_two_wire_frame_sender_top #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // From bit 0: segment_first, segment_second, segment_third, segment_fourth,
  // dio_sample, then zero padding.
  input  logic [39:0]                      s_axis_tdata,
  // Bit 0: operation (0 tick, 1 load).
  input  logic                             s_axis_tuser,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // From bit 0: clock_pull_low, data_pull_low, busy_res, ack_missing,
  // then zero padding.
  output logic [7:0]                       m_axis_tdata,
  // frame_done: this beat was the last bus phase of the frame.
  output logic                             m_axis_tlast,

  input  logic                             cfg_we_i,
  input  logic [ledtw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ledtw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ledtw_pkg::cfg_t    cfg_q;
  ledtw_pkg::item_t   item;
  ledtw_pkg::result_t step_res;
  ledtw_pkg::result_t out_res_q;
  logic               out_valid_q;
  logic               in_accept;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness      <= ledtw_pkg::BRIGHTNESS_RST;
      cfg_q.start_position  <= ledtw_pkg::START_POSITION_RST;
      cfg_q.data_command    <= ledtw_pkg::DATA_COMMAND_RST;
      cfg_q.address_command <= ledtw_pkg::ADDRESS_COMMAND_RST;
      cfg_q.control_command <= ledtw_pkg::CONTROL_COMMAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ledtw_pkg::REG_BRIGHTNESS:      cfg_q.brightness      <= cfg_data_i[3:0];
        ledtw_pkg::REG_START_POSITION:  cfg_q.start_position  <= cfg_data_i[1:0];
        ledtw_pkg::REG_DATA_COMMAND:    cfg_q.data_command    <= cfg_data_i;
        ledtw_pkg::REG_ADDRESS_COMMAND: cfg_q.address_command <= cfg_data_i;
        ledtw_pkg::REG_CONTROL_COMMAND: cfg_q.control_command <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.operation      = s_axis_tuser;
    item.segment_first  = s_axis_tdata[7:0];
    item.segment_second = s_axis_tdata[15:8];
    item.segment_third  = s_axis_tdata[23:16];
    item.segment_fourth = s_axis_tdata[31:24];
    item.dio_sample     = s_axis_tdata[32];
  end

  // The output register frees up in the same cycle that its beat is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ledtw_engine #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q.ack_missing, out_res_q.busy_res,
                          out_res_q.data_pull_low, out_res_q.clock_pull_low};
  assign m_axis_tlast  = out_res_q.frame_done;

  // Each accepted beat shows up as an output beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted beat produced no output beat");

  // After any load the block reports a frame in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && s_axis_tuser == ledtw_pkg::OP_LOAD |=> out_res_q.busy_res)
    else $error("load did not leave the block busy");

  // The last phase of a frame leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.frame_done |-> !out_res_q.busy_res)
    else $error("frame done reported while still busy");

endmodule

/* bench/led_driver_two_wire_frame_sender_top_tb.sv */
`timescale 1ns / 100ps

module led_driver_two_wire_frame_sender_top_tb;

  // Bench for the two-wire LED frame sender. Every input beat on s_axis yields exactly one
  // beat on m_axis. A behavioral copy of the frame sequencer runs alongside the block and
  // predicts every output beat. The copy is updated at the clock edge where the input beat
  // is accepted. Its prediction is queued, and each output beat is checked against the
  // oldest entry in that queue.

  localparam int unsigned DIGITS = 4;
  localparam int unsigned IDX_W  = ledtw_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W = ledtw_pkg::CFG_DATA_W;

  // Bus phase geometry of one frame.
  localparam int BIT_PH   = 3;
  localparam int ACK_PH   = 4;
  localparam int BYTE_PH  = 8 * BIT_PH + ACK_PH;
  localparam int STOP_PH  = 3;
  localparam int SHORT_PH = 1 + BYTE_PH + STOP_PH;
  localparam int MID_PH   = 1 + BYTE_PH * (1 + DIGITS) + STOP_PH;
  localparam int FRAME_PH = SHORT_PH + MID_PH + SHORT_PH;

  // Beats that advance the sequencer in the random part: roughly six and a half frames.
  localparam int RANDOM_BEATS = 1350;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata  = '0;
  logic              s_axis_tuser  = ledtw_pkg::OP_TICK;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i     = '0;
  logic [DATA_W-1:0] cfg_data_i    = '0;

  led_driver_two_wire_frame_sender_top #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Behavioral copy of the sequencer: registers, frame state and pin levels.
  // ---------------------------------------------------------------------------------------
  ledtw_pkg::cfg_t shadow_cfg;
  logic            seq_busy;
  int              seq_phase;
  logic [7:0]      seq_digits [DIGITS];
  logic            seq_data_low;
  logic            seq_clock_low;
  logic            seq_nack;

  // Predicted output beats, oldest first.
  ledtw_pkg::result_t pin_results_q [$];

  int mismatches  = 0;
  int orphan_hits = 0;
  int cycle_count = 0;

  function automatic void reset_sequencer();
    shadow_cfg.brightness      = ledtw_pkg::BRIGHTNESS_RST;
    shadow_cfg.start_position  = ledtw_pkg::START_POSITION_RST;
    shadow_cfg.data_command    = ledtw_pkg::DATA_COMMAND_RST;
    shadow_cfg.address_command = ledtw_pkg::ADDRESS_COMMAND_RST;
    shadow_cfg.control_command = ledtw_pkg::CONTROL_COMMAND_RST;
    seq_busy      = 1'b0;
    seq_phase     = 0;
    foreach (seq_digits[i]) seq_digits[i] = '0;
    seq_data_low  = 1'b0;
    seq_clock_low = 1'b0;
    seq_nack      = 1'b0;
  endfunction

  function automatic void shadow_write(logic [IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      ledtw_pkg::REG_BRIGHTNESS:      shadow_cfg.brightness      = val[3:0];
      ledtw_pkg::REG_START_POSITION:  shadow_cfg.start_position  = val[1:0];
      ledtw_pkg::REG_DATA_COMMAND:    shadow_cfg.data_command    = val;
      ledtw_pkg::REG_ADDRESS_COMMAND: shadow_cfg.address_command = val;
      ledtw_pkg::REG_CONTROL_COMMAND: shadow_cfg.control_command = val;
      default: ;
    endcase
  endfunction

  // One phase at offset ofs within a start/bytes/stop transfer whose first byte is cmd.
  function automatic void transfer_phase(int ofs, int nbytes, logic [7:0] cmd, logic sample);
    int         body;
    int         q;
    int         k;
    int         b;
    int         sub;
    logic [7:0] xfer_byte;
    body = BYTE_PH * nbytes;
    if (ofs == 0) begin
      seq_data_low = 1'b1;
    end else if (ofs <= body) begin
      q = ofs - 1;
      k = q / BYTE_PH;
      b = q % BYTE_PH;
      xfer_byte = (k > 0) ? seq_digits[k-1] : cmd;
      if (b < 8 * BIT_PH) begin
        sub = b % BIT_PH;
        case (sub)
          0:       seq_clock_low = 1'b1;
          1:       seq_data_low  = ~xfer_byte[b / BIT_PH];
          default: seq_clock_low = 1'b0;
        endcase
      end else begin
        sub = b - 8 * BIT_PH;
        case (sub)
          0: begin
            seq_clock_low = 1'b1;
            seq_data_low  = 1'b0;
          end
          1: seq_clock_low = 1'b0;
          2: begin
            // A released data line at the sample point is a missing acknowledge.
            if (!sample) seq_data_low = 1'b1;
            else         seq_nack     = 1'b1;
          end
          default: seq_clock_low = 1'b1;
        endcase
      end
    end else begin
      sub = ofs - 1 - body;
      case (sub)
        0:       seq_data_low  = 1'b1;
        1:       seq_clock_low = 1'b0;
        default: seq_data_low  = 1'b0;
      endcase
    end
  endfunction

  function automatic void frame_phase(int p, logic sample);
    logic [7:0] cmd;
    if (p < SHORT_PH) begin
      transfer_phase(p, 1, shadow_cfg.data_command, sample);
    end else if (p < SHORT_PH + MID_PH) begin
      cmd = shadow_cfg.address_command + shadow_cfg.start_position;
      transfer_phase(p - SHORT_PH, 1 + DIGITS, cmd, sample);
    end else begin
      cmd = shadow_cfg.control_command + shadow_cfg.brightness;
      transfer_phase(p - SHORT_PH - MID_PH, 1, cmd, sample);
    end
  endfunction

  function automatic ledtw_pkg::result_t predict_pins(logic op, logic [31:0] segs, logic dio);
    ledtw_pkg::result_t r;
    logic               done;
    done = 1'b0;
    if (op == ledtw_pkg::OP_LOAD) begin
      // A load that arrives mid-frame is dropped.
      if (!seq_busy) begin
        foreach (seq_digits[i])
          seq_digits[i] = (i < ledtw_pkg::INPUT_DIGITS) ? segs[8*i +: 8] : 8'h00;
        seq_busy  = 1'b1;
        seq_phase = 0;
        seq_nack  = 1'b0;
      end
    end else if (seq_busy) begin
      frame_phase(seq_phase, dio);
      if (seq_phase + 1 >= FRAME_PH) begin
        seq_busy  = 1'b0;
        seq_phase = 0;
        done      = 1'b1;
      end else begin
        seq_phase = seq_phase + 1;
      end
    end
    r.clock_pull_low = seq_clock_low;
    r.data_pull_low  = seq_data_low;
    r.busy_res       = seq_busy;
    r.ack_missing    = seq_nack;
    r.frame_done     = done;
    return r;
  endfunction

  // Gap length for either side: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Output side: random back-pressure, with quiet stretches where tready stays high.
  // The checks read the values that were present before the edge, so they match the
  // edge at which the beat was taken.
  // ---------------------------------------------------------------------------------------
  int   sink_gap   = 0;
  logic sink_quiet = 1'b0;

  always @(posedge clk_i) begin
    ledtw_pkg::result_t exp_r;
    logic               bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_results_q.size() == 0) begin
        orphan_hits++;
        if (mismatches + orphan_hits <= MAX_REPORTS)
          $display("[%0d] output beat with nothing predicted: tdata=%h tlast=%b",
                   cycle_count, m_axis_tdata, m_axis_tlast);
      end else begin
        exp_r = pin_results_q.pop_front();
        bad = (m_axis_tdata[0] !== exp_r.clock_pull_low) ||
              (m_axis_tdata[1] !== exp_r.data_pull_low) ||
              (m_axis_tdata[2] !== exp_r.busy_res) ||
              (m_axis_tdata[3] !== exp_r.ack_missing) ||
              (m_axis_tdata[7:4] !== 4'h0) ||
              (m_axis_tlast !== exp_r.frame_done);
        if (bad) begin
          mismatches++;
          if (mismatches + orphan_hits <= MAX_REPORTS)
            $display(
              "[%0d] mismatch clk/dat/busy/nack/done exp %b%b%b%b%b got %b%b%b%b%b pad %h",
              cycle_count,
              exp_r.clock_pull_low, exp_r.data_pull_low, exp_r.busy_res,
              exp_r.ack_missing, exp_r.frame_done,
              m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
              m_axis_tlast, m_axis_tdata[7:4]);
        end
      end
    end
    if ($urandom_range(0, 199) == 0) sink_quiet = ~sink_quiet;
    if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_quiet && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_driver_two_wire_frame_sender_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------------------
  logic src_quiet   = 1'b0;
  int   frame_beats = 0;

  // Presents one beat, waits until it is taken and queues what it should produce.
  // A typed expectation replaces the predicted one, but the predictor still advances.
  task automatic send_beat(input logic op, input logic [31:0] segs, input logic dio,
                           input logic typed, input ledtw_pkg::result_t typed_r);
    int                 gap;
    ledtw_pkg::result_t r;
    if ($urandom_range(0, 149) == 0) src_quiet = ~src_quiet;
    if (!src_quiet && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, dio, segs};
    do @(posedge clk_i); while (!s_axis_tready);
    if ((op == ledtw_pkg::OP_LOAD && !seq_busy) || (op == ledtw_pkg::OP_TICK && seq_busy))
      frame_beats++;
    r = predict_pins(op, segs, dio);
    pin_results_q.push_back(typed ? typed_r : r);
  endtask

  // Lets every predicted beat arrive, then lets the block settle so that it is quiet.
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pin_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    shadow_write(idx, val);
  endtask

  // Register settings walked between frames: all ones, all zeros, the reset values,
  // then random values.
  task automatic reconfigure(input int k);
    ledtw_pkg::cfg_t s;
    case (k)
      0:       s = '1;
      1:       s = '0;
      2:       s = {ledtw_pkg::BRIGHTNESS_RST, ledtw_pkg::START_POSITION_RST,
                    ledtw_pkg::DATA_COMMAND_RST, ledtw_pkg::ADDRESS_COMMAND_RST,
                    ledtw_pkg::CONTROL_COMMAND_RST};
      default: s = ledtw_pkg::cfg_t'({$urandom, $urandom});
    endcase
    // The unused high bits of the narrow registers carry random junk that must be masked.
    write_reg(ledtw_pkg::REG_BRIGHTNESS,      {4'($urandom), s.brightness});
    write_reg(ledtw_pkg::REG_START_POSITION,  {6'($urandom), s.start_position});
    write_reg(ledtw_pkg::REG_DATA_COMMAND,    s.data_command);
    write_reg(ledtw_pkg::REG_ADDRESS_COMMAND, s.address_command);
    write_reg(ledtw_pkg::REG_CONTROL_COMMAND, s.control_command);
    // An index past the last register must leave everything alone.
    write_reg(IDX_W'($urandom_range(ledtw_pkg::REG_CONTROL_COMMAND + 1, (1 << IDX_W) - 1)),
              8'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_segment();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Directed rows, run with the reset register values. The first rows have their results
  // typed in: idle ticks, a load, a load during a frame, then the start condition and the
  // first clock fall. The remaining ticks walk into the command byte and use the
  // predictor.
  typedef struct packed {
    logic               op;
    logic [31:0]        segs;
    logic               dio;
    logic               typed;
    ledtw_pkg::result_t res;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam ledtw_pkg::result_t R_IDLE   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam ledtw_pkg::result_t R_LOADED = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam ledtw_pkg::result_t R_START  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam ledtw_pkg::result_t R_CLKLOW = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

  stim_row_t dir_rows [DIR_ROWS];

  initial begin
    int                 setting_no;
    int                 idle_ticks;
    int                 nack_mode;
    logic               dio;
    ledtw_pkg::result_t unused_r;

    unused_r = R_IDLE;
    reset_sequencer();
    dir_rows[0] = '{ledtw_pkg::OP_TICK, 32'h0000_0000, 1'b0, 1'b1, R_IDLE};
    // Segment and sample fields are don't-care on an idle tick.
    dir_rows[1] = '{ledtw_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, R_IDLE};
    dir_rows[2] = '{ledtw_pkg::OP_LOAD, 32'h00FF_00FF, 1'b0, 1'b1, R_LOADED};
    // A load during a frame is dropped; the stored digits stay as they are.
    dir_rows[3] = '{ledtw_pkg::OP_LOAD, 32'h1234_5678, 1'b1, 1'b1, R_LOADED};
    dir_rows[4] = '{ledtw_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, R_START};
    dir_rows[5] = '{ledtw_pkg::OP_TICK, 32'h0000_0000, 1'b0, 1'b1, R_CLKLOW};
    for (int i = 6; i < DIR_ROWS; i++)
      dir_rows[i] = '{ledtw_pkg::OP_TICK, 32'($urandom), 1'(i), 1'b0, unused_r};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].segs, dir_rows[i].dio,
                dir_rows[i].typed, dir_rows[i].res);

    // Random part: mostly complete frames with random digits and acknowledge patterns,
    // with idle ticks and dropped loads mixed in as noise. Only beats that move the
    // sequencer count toward the total.
    frame_beats = 0;
    setting_no  = 0;
    nack_mode   = 0;
    while (frame_beats < RANDOM_BEATS) begin
      if (!seq_busy) begin
        drain_outputs();
        reconfigure(setting_no);
        setting_no++;
        // Idle ticks here also show that ack_missing holds after a frame.
        idle_ticks = $urandom_range(0, 2);
        repeat (idle_ticks)
          send_beat(ledtw_pkg::OP_TICK, 32'($urandom), 1'($urandom), 1'b0, unused_r);
        // Per frame: always acknowledged, an occasional missing one, or coin flips.
        nack_mode = $urandom_range(0, 2);
        send_beat(ledtw_pkg::OP_LOAD,
                  {pick_segment(), pick_segment(), pick_segment(), pick_segment()},
                  1'($urandom), 1'b0, unused_r);
      end else if ($urandom_range(0, 63) == 0) begin
        send_beat(ledtw_pkg::OP_LOAD, 32'($urandom), 1'($urandom), 1'b0, unused_r);
      end else begin
        case (nack_mode)
          0:       dio = 1'b0;
          1:       dio = ($urandom_range(0, 29) == 0);
          default: dio = 1'($urandom);
        endcase
        send_beat(ledtw_pkg::OP_TICK, 32'($urandom), dio, 1'b0, unused_r);
      end
    end

    drain_outputs();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && orphan_hits == 0 && pin_results_q.size() == 0) begin
      $display("led_driver_two_wire_frame_sender_top verification clean");
    end else begin
      $display("led_driver_two_wire_frame_sender_top verification failed");
    end
    $finish;
  end

endmodule
